[design/tdp_pkg.sv]
// Shared types and constants for the trial-division primality tester.
// No dependencies; imported by tdp_rem and trial_division_primality.
`timescale 1ns / 1ps

package tdp_pkg;

	localparam int NUM_W = 32;          // number field width
	localparam int TAG_W = 16;          // tag field width
	localparam int DIV_W = 16;          // trial divisor, max 46341
	localparam int SQ_W  = 33;          // divisor square, never overflows
	localparam int CNT_W = $clog2(NUM_W);
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
	localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);
	localparam logic [SQ_W-1:0]  SQ_STEP_C = SQ_W'(4);

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_REM,
		ST_DONE
	} tdp_state_t;

	// Status returned by the serial remainder unit
	typedef struct packed {
		logic done;   // one-cycle pulse, remainder final
		logic zero;   // remainder is zero (valid with done)
	} tdp_rem_st_t;

endpackage

[design/tdp_rem.sv]
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_rem import tdp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,   // held stable while busy
	output tdp_rem_st_t      status
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] sh_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// One restoring step: bring in the next bit, subtract if it fits
	assign trial = {r_q, sh_q[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[NUM_W-2:0], 1'b0};
			r_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign status.done = done_q;
	assign status.zero = (r_q == '0);

	// Partial remainder stays below the divisor through the pass
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && $past(busy_q) |-> r_q < divisor)
		else $error("partial remainder not below divisor");

	// A done pulse marks the end of a pass: busy drops with its last step
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("done without a finished pass");

	// Start always launches a pass
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("start did not launch a pass");

endmodule

[design/trial_division_primality.sv]
// Trial-division primality tester, top level. Negative, zero, one and even numbers are
// decided without a divisor search; odd numbers are tried against odd divisors (3, 5,
// 7 and on while d*d <= n), one bit-serial remainder pass per divisor. Throughput: one
// number at a time, the next taken in the cycle the result turns valid; a full output
// register stalls the input. Reset (arst_n low) returns to idle with no result pending.
// Depends on tdp_pkg and tdp_rem.
`timescale 1ns / 1ps

module trial_division_primality import tdp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] number, [47:32] tag
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [0] is_prime, [16:1] tag_out, rest 0
);

	tdp_state_t       state_q, state_nx;
	logic [NUM_W-1:0] num_q;
	logic [TAG_W-1:0] tag_q;
	logic [DIV_W-1:0] d_q;
	logic [SQ_W-1:0]  sq_q;
	logic             prime_q;
	logic             out_valid_q;
	logic             out_prime_q;
	logic [TAG_W-1:0] out_tag_q;

	logic             in_acc;
	logic             rem_start;
	logic             load_out;
	logic             out_free;
	logic             sq_over;
	tdp_rem_st_t      rem_st;

	logic [NUM_W-1:0] in_num;
	logic [TAG_W-1:0] in_tag;
	logic             in_trivial;   // decided without trial division

	assign in_num = s_tdata[NUM_W-1:0];
	assign in_tag = s_tdata[NUM_W +: TAG_W];

	// Negative, zero, one and even numbers need no divisor search
	assign in_trivial = in_num[NUM_W-1] || (in_num <= NUM_W'(1)) || !in_num[0];
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign sq_over    = (sq_q > {1'b0, num_q});

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nx = in_trivial ? ST_DONE : ST_TEST;
			end
			ST_TEST: begin
				state_nx = sq_over ? ST_DONE : ST_REM;
			end
			ST_REM: begin
				if (rem_st.done) state_nx = rem_st.zero ? ST_DONE : ST_TEST;
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready  = 1'b0;
		rem_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_TEST: rem_start = !sq_over;
			ST_REM:  ;
			ST_DONE: load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Search registers: divisor, its square, verdict
	always_ff @(posedge clk) begin
		if (in_acc) begin
			num_q   <= in_num;
			tag_q   <= in_tag;
			d_q     <= FIRST_DIV;
			sq_q    <= FIRST_SQ;
			// only 2 is prime among the trivial cases
			prime_q <= (in_num == NUM_W'(2));
		end else if (state_q == ST_TEST && sq_over) begin
			prime_q <= 1'b1;
		end else if (state_q == ST_REM && rem_st.done) begin
			if (rem_st.zero) begin
				prime_q <= 1'b0;
			end else begin
				// (d+2)^2 = d^2 + 4d + 4
				d_q  <= d_q + DIV_W'(2);
				sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_STEP_C;
			end
		end
	end

	tdp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (num_q),
		.divisor  (d_q),
		.status   (rem_st)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_prime_q <= prime_q;
			out_tag_q   <= tag_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - TAG_W - 1){1'b0}}, out_tag_q, out_prime_q};

	// Divisor under test is always odd and at least three
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REM |-> d_q[0] && d_q >= FIRST_DIV)
		else $error("trial divisor not odd");

	// Running square tracks the divisor
	a_sq_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEST |-> sq_q == SQ_W'(32'(d_q) * 32'(d_q)))
		else $error("divisor square out of step");

	// Remainder unit reports only while the controller waits on it
	a_rem_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rem_st.done |-> state_q == ST_REM)
		else $error("remainder result outside wait state");

	// A result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || m_tready)
		else $error("pending result overwritten");

endmodule
